// File: rtl/core/pale_pkg.sv
// ----------------------------------------------------------------------------
// pale_pkg: shared types and constants of the positional array list engine
// Command and status codes, field widths and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package pale_pkg;

  // default list capacity
  localparam int DEPTH_DEF = 64;

  // fixed field widths
  localparam int CMD_W  = 3;
  localparam int POS_W  = 7;
  localparam int DATA_W = 32;
  localparam int STS_W  = 3;

  typedef logic [CMD_W-1:0] cmd_t;
  typedef logic [STS_W-1:0] status_t;
  typedef logic [1:0]       rd_sel_t;

  // command codes
  localparam cmd_t CMD_CLEAR  = 3'd0;
  localparam cmd_t CMD_INSERT = 3'd1;
  localparam cmd_t CMD_DELETE = 3'd2;
  localparam cmd_t CMD_SEARCH = 3'd3;
  localparam cmd_t CMD_READ   = 3'd4;

  // result status codes
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_FULL     = 3'd1;
  localparam status_t ST_EMPTY    = 3'd2;
  localparam status_t ST_BADPOS   = 3'd3;
  localparam status_t ST_NOTFOUND = 3'd4;

  // memory read address relative to the index register
  localparam rd_sel_t RD_SAME = 2'd0;
  localparam rd_sel_t RD_PREV = 2'd1;
  localparam rd_sel_t RD_NEXT = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic    load_in;   // capture the input beat
    logic    idx_cnt;   // index <= count
    logic    idx_pos;   // index <= position - 1
    logic    idx_zero;  // index <= 0
    logic    idx_inc;
    logic    idx_dec;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    logic    wr_ins;    // write the insert value instead of the read data
    logic    cnt_clr;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    st_we;
    status_t st_val;
    logic    found_we;  // found position <= index + 1
    logic    data_we;   // read data <= memory read data
    logic    res_load;  // move the pending result into the output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic empty;
    logic ins_pos_ok;
    logic acc_pos_ok;
    logic ins_more;
    logic del_more;
    logic srch_more;
    logic match;
    logic out_free;
  } dp_sts_t;

endpackage

// File: rtl/core/pale_if.sv
// ----------------------------------------------------------------------------
// pale_if: channel interfaces of the positional array list engine
// Command channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface pale_in_if;
  logic                        valid;
  logic                        ready;
  logic [pale_pkg::CMD_W-1:0]  command;
  logic [pale_pkg::POS_W-1:0]  position;
  logic signed [pale_pkg::DATA_W-1:0] insert_value;
  logic signed [pale_pkg::DATA_W-1:0] search_key;

  modport source (output valid, command, position, insert_value, search_key,
                  input ready);
  modport sink (input valid, command, position, insert_value, search_key,
                output ready);
endinterface

interface pale_out_if;
  logic                        valid;
  logic                        ready;
  logic [pale_pkg::STS_W-1:0]  status;
  logic [pale_pkg::POS_W-1:0]  found_position;
  logic signed [pale_pkg::DATA_W-1:0] read_data;
  logic [pale_pkg::POS_W-1:0]  element_count;

  modport source (output valid, status, found_position, read_data, element_count,
                  input ready);
  modport sink (input valid, status, found_position, read_data, element_count,
                output ready);
endinterface

// File: rtl/core/pale_ctrl.sv
// ----------------------------------------------------------------------------
// pale_ctrl: command sequencer
// Decodes each accepted beat and steps the datapath through the shift,
// scan or read loop, then hands the result to the output register.
// ----------------------------------------------------------------------------
module pale_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pale_pkg::dp_sts_t sts,
  output pale_pkg::dp_cmd_t cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_INS_CHK = 4'd2;
  localparam logic [3:0] S_INS_WR  = 4'd3;
  localparam logic [3:0] S_DEL_CHK = 4'd4;
  localparam logic [3:0] S_DEL_WR  = 4'd5;
  localparam logic [3:0] S_SR_CHK  = 4'd6;
  localparam logic [3:0] S_SR_CMP  = 4'd7;
  localparam logic [3:0] S_RD_ISS  = 4'd8;
  localparam logic [3:0] S_RD_TAKE = 4'd9;
  localparam logic [3:0] S_FIN     = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.cmd)
          pale_pkg::CMD_CLEAR: begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = S_FIN;
          end
          pale_pkg::CMD_INSERT: begin
            priority if (sts.full) begin
              cmd.st_we  = 1'b1;
              cmd.st_val = pale_pkg::ST_FULL;
              state_nxt  = S_FIN;
            end else if (!sts.ins_pos_ok) begin
              cmd.st_we  = 1'b1;
              cmd.st_val = pale_pkg::ST_BADPOS;
              state_nxt  = S_FIN;
            end else begin
              cmd.idx_cnt = 1'b1;
              state_nxt   = S_INS_CHK;
            end
          end
          pale_pkg::CMD_DELETE, pale_pkg::CMD_READ: begin
            priority if (sts.empty) begin
              cmd.st_we  = 1'b1;
              cmd.st_val = pale_pkg::ST_EMPTY;
              state_nxt  = S_FIN;
            end else if (!sts.acc_pos_ok) begin
              cmd.st_we  = 1'b1;
              cmd.st_val = pale_pkg::ST_BADPOS;
              state_nxt  = S_FIN;
            end else begin
              cmd.idx_pos = 1'b1;
              state_nxt   = (sts.cmd == pale_pkg::CMD_READ) ? S_RD_ISS : S_DEL_CHK;
            end
          end
          pale_pkg::CMD_SEARCH: begin
            if (sts.empty) begin
              cmd.st_we  = 1'b1;
              cmd.st_val = pale_pkg::ST_EMPTY;
              state_nxt  = S_FIN;
            end else begin
              cmd.idx_zero = 1'b1;
              state_nxt    = S_SR_CHK;
            end
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      // move entries toward the end, last one first
      S_INS_CHK: begin
        if (sts.ins_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = pale_pkg::RD_PREV;
          state_nxt  = S_INS_WR;
        end else begin
          cmd.wr_en   = 1'b1;
          cmd.wr_ins  = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_INS_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.idx_dec = 1'b1;
        state_nxt   = S_INS_CHK;
      end
      // close the gap, first one first
      S_DEL_CHK: begin
        if (sts.del_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = pale_pkg::RD_NEXT;
          state_nxt  = S_DEL_WR;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_DEL_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = S_DEL_CHK;
      end
      // linear scan from the head
      S_SR_CHK: begin
        if (sts.srch_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = pale_pkg::RD_SAME;
          state_nxt  = S_SR_CMP;
        end else begin
          cmd.st_we  = 1'b1;
          cmd.st_val = pale_pkg::ST_NOTFOUND;
          state_nxt  = S_FIN;
        end
      end
      S_SR_CMP: begin
        if (sts.match) begin
          cmd.found_we = 1'b1;
          state_nxt    = S_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SR_CHK;
        end
      end
      S_RD_ISS: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = pale_pkg::RD_SAME;
        state_nxt  = S_RD_TAKE;
      end
      S_RD_TAKE: begin
        cmd.data_we = 1'b1;
        state_nxt   = S_FIN;
      end
      // wait for the output register to drain
      S_FIN: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // a loop step never starts on an idle sequencer
  a_idle_no_mem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !(cmd.wr_en || cmd.rd_en || cmd.res_load))
    else $error("memory or result activity while idle");

  // an accepted beat is always decoded next
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECODE))
    else $error("accepted beat not decoded");

endmodule

// File: rtl/core/pale_dp.sv
// ----------------------------------------------------------------------------
// pale_dp: list storage, index, count and result registers
// Single-write, single-read memory with registered read data; the sequencer
// moves entries through it one at a time, a registered read and then a write.
// ----------------------------------------------------------------------------
module pale_dp #(
  parameter int DEPTH = pale_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input beat payload
  input  logic [pale_pkg::CMD_W-1:0]        in_command,
  input  logic [pale_pkg::POS_W-1:0]        in_position,
  input  logic signed [pale_pkg::DATA_W-1:0] in_insert_value,
  input  logic signed [pale_pkg::DATA_W-1:0] in_search_key,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pale_pkg::STS_W-1:0]        out_status,
  output logic [pale_pkg::POS_W-1:0]        out_found_position,
  output logic signed [pale_pkg::DATA_W-1:0] out_read_data,
  output logic [pale_pkg::POS_W-1:0]        out_element_count,
  // sequencer link
  input  pale_pkg::dp_cmd_t                 cmd,
  output pale_pkg::dp_sts_t                 sts
);

  localparam int PW     = pale_pkg::POS_W;
  localparam int DW     = pale_pkg::DATA_W;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W  = ((CNT_W > PW) ? CNT_W : PW) + 1;

  // captured command
  pale_pkg::cmd_t  cmd_r;
  logic [PW-1:0]   pos_r;
  logic [DW-1:0]   val_r;
  logic [DW-1:0]   key_r;

  // list state
  logic [DW-1:0]    mem [DEPTH];
  logic [DW-1:0]    rdata_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;

  // pending result
  pale_pkg::status_t pend_status_r;
  logic [PW-1:0]     pend_found_r;
  logic [DW-1:0]     pend_data_r;

  // output register
  logic               out_valid_r;
  pale_pkg::status_t  out_status_r;
  logic [PW-1:0]      out_found_r;
  logic [DW-1:0]      out_data_r;
  logic [PW-1:0]      out_count_r;

  logic [CMP_W-1:0]  pos_e, cnt_e, idx_e;
  logic [CNT_W-1:0]  rd_idx;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [DW-1:0]     wr_data;

  assign pos_e = CMP_W'(pos_r);
  assign cnt_e = CMP_W'(count_r);
  assign idx_e = CMP_W'(idx_r);

  // capture the input beat
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r <= in_command;
      pos_r <= in_position;
      val_r <= in_insert_value;
      key_r <= in_search_key;
    end
  end

  // index register
  always_comb begin
    idx_nxt = idx_r;
    priority if (cmd.idx_cnt) begin
      idx_nxt = count_r;
    end else if (cmd.idx_pos) begin
      idx_nxt = CNT_W'(pos_e - CMP_W'(1));
    end else if (cmd.idx_zero) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + CNT_W'(1);
    end else if (cmd.idx_dec) begin
      idx_nxt = idx_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

  // entry count
  always_comb begin
    count_nxt = count_r;
    priority if (cmd.cnt_clr) begin
      count_nxt = '0;
    end else if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // memory addressing
  always_comb begin
    unique case (cmd.rd_sel)
      pale_pkg::RD_PREV: rd_idx = idx_r - CNT_W'(1);
      pale_pkg::RD_NEXT: rd_idx = idx_r + CNT_W'(1);
      default:           rd_idx = idx_r;
    endcase
  end

  assign rd_addr = rd_idx[ADDR_W-1:0];
  assign wr_addr = idx_r[ADDR_W-1:0];
  assign wr_data = cmd.wr_ins ? val_r : rdata_r;

  // list memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // pending result fields
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      pend_status_r <= pale_pkg::ST_OK;
      pend_found_r  <= '0;
      pend_data_r   <= '0;
    end else begin
      if (cmd.st_we) begin
        pend_status_r <= cmd.st_val;
      end
      if (cmd.found_we) begin
        pend_found_r <= PW'(idx_e + CMP_W'(1));
      end
      if (cmd.data_we) begin
        pend_data_r <= rdata_r;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_status_r <= pend_status_r;
      out_found_r  <= pend_found_r;
      out_data_r   <= pend_data_r;
      out_count_r  <= PW'(cnt_e);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_found_r;
  assign out_read_data      = out_data_r;
  assign out_element_count  = out_count_r;

  // status toward the sequencer
  always_comb begin
    sts            = '0;
    sts.cmd        = cmd_r;
    sts.full       = (cnt_e >= CMP_W'(DEPTH));
    sts.empty      = (count_r == '0);
    sts.ins_pos_ok = (pos_r != '0) && (pos_e <= cnt_e + CMP_W'(1));
    sts.acc_pos_ok = (pos_r != '0) && (pos_e <= cnt_e);
    sts.ins_more   = (idx_e >= pos_e);
    sts.del_more   = (idx_e + CMP_W'(1) < cnt_e);
    sts.srch_more  = (idx_e < cnt_e);
    sts.match      = (rdata_r == key_r);
    sts.out_free   = !out_valid_r || out_ready;
  end

  // count never exceeds capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(DEPTH))
    else $error("entry count above capacity");

  // count moves by one or is cleared
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == '0 || count_r == $past(count_r) + CNT_W'(1) ||
       count_r == $past(count_r) - CNT_W'(1)))
    else $error("entry count jumped");

  // writes stay inside the array
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> (idx_e < CMP_W'(DEPTH)))
    else $error("write outside the list");

  // a result never overwrites one still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> (!out_valid_r || out_ready))
    else $error("result overwritten before taken");

endmodule

// File: rtl/core/positional_array_list_engine.sv
// ----------------------------------------------------------------------------
// positional_array_list_engine: ordered list with insert, delete, search, read
// One command in flight; each moved or scanned entry takes a registered read of
// the single-write, single-read list memory, then a write or a compare.
// Synchronous active-low reset empties the list; entry contents stay unknown.
// ----------------------------------------------------------------------------
module positional_array_list_engine #(
  parameter int DEPTH = pale_pkg::DEPTH_DEF  // capacity, 1 to 127 at 7-bit fields
) (
  input  logic        clk,
  input  logic        rst_n,
  pale_in_if.sink     in_bus,
  pale_out_if.source  out_bus
);

  pale_pkg::dp_cmd_t dp_cmd;
  pale_pkg::dp_sts_t dp_sts;

  // command sequencer
  pale_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  // storage and result path
  pale_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_command         (in_bus.command),
    .in_position        (in_bus.position),
    .in_insert_value    (in_bus.insert_value),
    .in_search_key      (in_bus.search_key),
    .out_valid          (out_bus.valid),
    .out_ready          (out_bus.ready),
    .out_status         (out_bus.status),
    .out_found_position (out_bus.found_position),
    .out_read_data      (out_bus.read_data),
    .out_element_count  (out_bus.element_count),
    .cmd                (dp_cmd),
    .sts                (dp_sts)
  );

endmodule

// File: sim/pale_list_checker.sv
// ----------------------------------------------------------------------------
// pale_list_checker: result checker for the positional array list engine
// Watches the command and result channels. It keeps its own copy of the list
// and the count, works out the result of every accepted command beat, and
// compares each result beat field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module pale_list_checker
  import pale_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  pale_in_if   in_mon,
  pale_out_if  out_mon,
  output int   fail_count,
  output int   pending_count
);

  localparam int LIST_DEPTH = DEPTH_DEF;

  typedef struct packed {
    status_t                   status;
    logic [POS_W-1:0]          found_position;
    logic signed [DATA_W-1:0]  read_data;
    logic [POS_W-1:0]          element_count;
  } list_result_t;

  // shadow copy of the list
  logic signed [DATA_W-1:0] list_mem [LIST_DEPTH];
  int                       list_len;

  list_result_t expected_results [$];
  int           result_index;

  task automatic report_mismatch(string msg);
    $display("result %0d: %s", result_index, msg);
    fail_count++;
  endtask

  // apply one command to the shadow list and return the result it yields
  function automatic list_result_t apply_list_command(cmd_t cmd, logic [POS_W-1:0] pos,
                                                      logic signed [DATA_W-1:0] val,
                                                      logic signed [DATA_W-1:0] key);
    list_result_t res;
    int           p;
    int           i;
    res        = '0;
    res.status = ST_OK;
    p          = int'(pos);
    case (cmd)
      CMD_CLEAR: begin
        list_len = 0;
      end
      CMD_INSERT: begin
        if (list_len >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else if (p < 1 || p > list_len + 1) begin
          res.status = ST_BADPOS;
        end else begin
          for (i = list_len; i >= p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p-1] = val;
          list_len++;
        end
      end
      CMD_DELETE: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (p < 1 || p > list_len) begin
          res.status = ST_BADPOS;
        end else begin
          for (i = p - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      CMD_SEARCH: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.status = ST_NOTFOUND;
          for (i = 0; i < list_len; i++) begin
            if (list_mem[i] == key) begin
              res.status         = ST_OK;
              res.found_position = POS_W'(i + 1);
              break;
            end
          end
        end
      end
      CMD_READ: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (p < 1 || p > list_len) begin
          res.status = ST_BADPOS;
        end else begin
          res.read_data = list_mem[p-1];
        end
      end
      default: ;  // spare codes leave the list alone
    endcase
    res.element_count = POS_W'(list_len);
    return res;
  endfunction

  // result beats are matched before command beats of the same edge
  always @(posedge clk) begin
    list_result_t want;
    list_result_t got;
    if (!rst_n) begin
      list_len = 0;
      expected_results.delete();
      result_index = 0;
      fail_count = 0;
      pending_count <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.status         = out_mon.status;
        got.found_position = out_mon.found_position;
        got.read_data      = out_mon.read_data;
        got.element_count  = out_mon.element_count;
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with no command waiting");
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status expected %0d got %0d",
                                      want.status, got.status));
          if (got.found_position !== want.found_position)
            report_mismatch($sformatf("found_position expected %0d got %0d",
                                      want.found_position, got.found_position));
          if (got.read_data !== want.read_data)
            report_mismatch($sformatf("read_data expected %0d got %0d",
                                      want.read_data, got.read_data));
          if (got.element_count !== want.element_count)
            report_mismatch($sformatf("element_count expected %0d got %0d",
                                      want.element_count, got.element_count));
        end
        result_index++;
      end
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(apply_list_command(in_mon.command, in_mon.position,
                                                      in_mon.insert_value,
                                                      in_mon.search_key));
      pending_count <= expected_results.size();
    end
  end

endmodule

// File: sim/positional_array_list_engine_test.sv
// ----------------------------------------------------------------------------
// positional_array_list_engine_test: testbench top of the list engine
// Drives directed list commands, then random grow and shrink sequences with
// random gaps and stalls on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module positional_array_list_engine_test;
  import pale_pkg::*;

  localparam int   ITEM_TOTAL       = 1500;
  localparam int   CYCLE_LIMIT      = 1_500_000;
  localparam int   LIST_DEPTH       = DEPTH_DEF;
  localparam int   LONG_HOLD_CYCLES = 600;
  localparam int   LONG_HOLD_AFTER  = 300;
  localparam int   MID_DRAIN_ITEM   = 750;
  localparam int   SETTLE_CYCLES    = 20;
  localparam cmd_t CMD_SPARE_5      = 3'd5;
  localparam cmd_t CMD_SPARE_7      = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VALUE_POOL [8] = '{
    32'sd0, -32'sd1, 32'sd1, 32'sh8000_0000, 32'sh7FFF_FFFF,
    32'sh5555_5555, 32'shAAAA_AAAA, 32'sd100
  };

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   cycle_count;
  int   results_seen;
  int   shadow_len;
  bit   sender_steady;
  bit   receiver_steady;

  pale_in_if  in_bus ();
  pale_out_if out_bus ();

  positional_array_list_engine dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  pale_list_checker list_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_bus),
    .out_mon       (out_bus),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 1;
    if (r < 85) return $urandom_range(2, 4);
    if (r < 96) return $urandom_range(5, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic sender_idle(int n);
    in_bus.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // offer one beat, wait for it to be taken, then maybe leave a gap
  task automatic send_beat(cmd_t cmd, logic [POS_W-1:0] pos,
                           logic signed [DATA_W-1:0] val, logic signed [DATA_W-1:0] key);
    in_bus.valid        <= 1'b1;
    in_bus.command      <= cmd;
    in_bus.position     <= pos;
    in_bus.insert_value <= val;
    in_bus.search_key   <= key;
    do @(posedge clk); while (!in_bus.ready);
    // rough list length, only used to aim positions
    case (cmd)
      CMD_CLEAR:  shadow_len = 0;
      CMD_INSERT: if (shadow_len < LIST_DEPTH && pos >= 1 && pos <= shadow_len + 1)
                    shadow_len++;
      CMD_DELETE: if (shadow_len > 0 && pos >= 1 && pos <= shadow_len) shadow_len--;
      default: ;
    endcase
    if (!sender_steady && $urandom_range(0, 99) < 30) sender_idle(gap_len());
  endtask

  // stop offering until every result is back
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 45) return VALUE_POOL[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // mostly in-range positions, some on the edges, some anywhere
  function automatic logic [POS_W-1:0] pick_position(cmd_t cmd);
    int r;
    int limit;
    r     = $urandom_range(0, 99);
    limit = (cmd == CMD_INSERT) ? shadow_len + 1 : shadow_len;
    if (r < 85 && limit >= 1) return POS_W'($urandom_range(1, limit));
    if (r < 90) return '0;
    if (r < 95) return POS_W'(limit + 1);
    return POS_W'($urandom_range(0, 127));
  endfunction

  task automatic send_random_item(bit growing);
    int   r;
    cmd_t cmd;
    r = $urandom_range(0, 99);
    if (growing) begin
      if      (r < 55) cmd = CMD_INSERT;
      else if (r < 65) cmd = CMD_DELETE;
      else if (r < 80) cmd = CMD_SEARCH;
      else if (r < 95) cmd = CMD_READ;
      else if (r < 96) cmd = CMD_CLEAR;
      else             cmd = cmd_t'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
    end else begin
      if      (r < 15) cmd = CMD_INSERT;
      else if (r < 60) cmd = CMD_DELETE;
      else if (r < 75) cmd = CMD_SEARCH;
      else if (r < 93) cmd = CMD_READ;
      else if (r < 95) cmd = CMD_CLEAR;
      else             cmd = cmd_t'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
    end
    send_beat(cmd, pick_position(cmd), pick_value(), pick_value());
  endtask

  // result side: random stalls, one long hold-off
  initial begin
    int  stall_left;
    int  tick;
    bit  held_long;
    out_bus.ready <= 1'b0;
    stall_left      = 0;
    tick            = 0;
    held_long       = 1'b0;
    receiver_steady = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (out_bus.valid && out_bus.ready) results_seen++;
      if (tick % 256 == 0) receiver_steady = ($urandom_range(0, 99) < 30);
      if (!rst_n) begin
        out_bus.ready <= 1'b0;
      end else if (!held_long && results_seen >= LONG_HOLD_AFTER) begin
        held_long = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
        if (!receiver_steady && $urandom_range(0, 99) < 25) stall_left = gap_len();
      end
    end
  end

  // command side
  initial begin
    bit growing;
    int n;
    rst_n               <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.command      <= CMD_CLEAR;
    in_bus.position     <= '0;
    in_bus.insert_value <= '0;
    in_bus.search_key   <= '0;
    shadow_len    = 0;
    sender_steady = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list, bad positions, ends of the list, spare codes
    send_beat(CMD_CLEAR,  7'd0,   32'sd0,  32'sd0);
    send_beat(CMD_READ,   7'd1,   32'sd0,  32'sd0);
    send_beat(CMD_DELETE, 7'd1,   32'sd0,  32'sd0);
    send_beat(CMD_SEARCH, 7'd0,   32'sd0,  32'sd0);
    send_beat(CMD_INSERT, 7'd0,   32'sd5,  32'sd0);
    send_beat(CMD_INSERT, 7'd2,   32'sd5,  32'sd0);
    send_beat(CMD_INSERT, 7'd1,   VAL_MIN, 32'sd0);
    send_beat(CMD_INSERT, 7'd2,   VAL_MAX, 32'sd0);
    send_beat(CMD_INSERT, 7'd1,   32'sd0,  32'sd0);
    send_beat(CMD_INSERT, 7'd2,   -32'sd1, 32'sd0);
    send_beat(CMD_INSERT, 7'd5,   32'sd0,  32'sd0);
    send_beat(CMD_SEARCH, 7'd0,   32'sd0,  32'sd0);
    send_beat(CMD_SEARCH, 7'd0,   32'sd0,  VAL_MAX);
    send_beat(CMD_SEARCH, 7'd0,   32'sd0,  32'sd12345);
    send_beat(CMD_READ,   7'd0,   32'sd0,  32'sd0);
    send_beat(CMD_READ,   7'd6,   32'sd0,  32'sd0);
    send_beat(CMD_READ,   7'd127, 32'sd0,  32'sd0);
    send_beat(CMD_READ,   7'd3,   32'sd0,  32'sd0);
    send_beat(CMD_DELETE, 7'd5,   32'sd0,  32'sd0);
    send_beat(CMD_DELETE, 7'd1,   32'sd0,  32'sd0);
    send_beat(CMD_DELETE, 7'd0,   32'sd0,  32'sd0);
    send_beat(CMD_DELETE, 7'd4,   32'sd0,  32'sd0);
    for (n = CMD_SPARE_5; n <= CMD_SPARE_7; n++)
      send_beat(cmd_t'(n), 7'd1, VAL_MAX, VAL_MIN);
    drain_results();

    // random grow and shrink sequences
    growing = 1'b1;
    for (n = 0; n < ITEM_TOTAL; n++) begin
      if (n % 100 == 0) sender_steady = ($urandom_range(0, 99) < 30);
      if (n == MID_DRAIN_ITEM) drain_results();
      if (shadow_len == 0) growing = 1'b1;
      else if (shadow_len == LIST_DEPTH && $urandom_range(0, 9) == 0) growing = 1'b0;
      else if ($urandom_range(0, 99) == 0) growing = !growing;
      send_random_item(growing);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/pale_pkg.sv
rtl/core/pale_if.sv
rtl/core/pale_ctrl.sv
rtl/core/pale_dp.sv
rtl/core/positional_array_list_engine.sv
sim/pale_list_checker.sv
sim/positional_array_list_engine_test.sv
